// ----- sv/srel_pkg.sv -----
// ============================================================================
// srel_pkg
// Shared types and codes for the set relation classifier.
// ============================================================================
package srel_pkg;

    localparam int MAX_ELEMENTS_DEFAULT = 64;

    localparam int OP_W    = 2;
    localparam int ELEM_W  = 32;
    localparam int REL_W   = 3;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 8;

    // Item kinds
    localparam logic [OP_W-1:0] OP_ADD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_TEST_B = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    // Relation codes
    localparam logic [REL_W-1:0] REL_EQUAL    = 3'd0;
    localparam logic [REL_W-1:0] REL_B_SUB_A  = 3'd1;
    localparam logic [REL_W-1:0] REL_A_SUB_B  = 3'd2;
    localparam logic [REL_W-1:0] REL_DISJOINT = 3'd3;
    localparam logic [REL_W-1:0] REL_OVERLAP  = 3'd4;

    // One item moving from the input register into the processing stage
    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
    } step_t;

endpackage

// ----- sv/srel_match_table.sv -----
// ============================================================================
// srel_match_table
// Storage for set A elements with a parallel equality compare on every entry.
// ============================================================================
module srel_match_table #(
    parameter int MAX_ELEMENTS = srel_pkg::MAX_ELEMENTS_DEFAULT,
    parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1),
    parameter int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [srel_pkg::ELEM_W-1:0] wr_data,
    input  logic [srel_pkg::ELEM_W-1:0] cmp_data,
    input  logic [CNT_W-1:0]          a_size,
    output logic                      hit
);

    logic [srel_pkg::ELEM_W-1:0] entry_reg [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]     match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    // only entries below the stored count take part
    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cmp
        assign match[i] = (CNT_W'(i) < a_size) && (entry_reg[i] == cmp_data);
    end

    assign hit = |match;

endmodule

// ----- sv/srel_tracker.sv -----
// ============================================================================
// srel_tracker
// Set sizes, hit count, sticky overflow flag and the final classification.
// ============================================================================
module srel_tracker #(
    parameter int MAX_ELEMENTS = srel_pkg::MAX_ELEMENTS_DEFAULT,
    parameter int CNT_W        = $clog2(MAX_ELEMENTS + 1),
    parameter int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  srel_pkg::step_t            step,
    input  logic                       hit,
    output logic                       a_wr_en,
    output logic [IDX_W-1:0]           a_wr_idx,
    output logic [CNT_W-1:0]           a_size,
    output logic [srel_pkg::REL_W-1:0] relation,
    output logic                       overflow
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ELEMENTS);

    logic [CNT_W-1:0] a_size_reg, a_size_next;
    logic [CNT_W-1:0] b_size_reg, b_size_next;
    logic [CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic             ovf_reg, ovf_next;

    assign a_size   = a_size_reg;
    assign a_wr_idx = a_size_reg[IDX_W-1:0];
    assign a_wr_en  = step.valid && (step.op == srel_pkg::OP_ADD_A) && (a_size_reg < CAP);

    always_comb
    begin
        a_size_next  = a_size_reg;
        b_size_next  = b_size_reg;
        hit_cnt_next = hit_cnt_reg;
        ovf_next     = ovf_reg;
        if (step.valid)
        begin
            case (step.op)
                srel_pkg::OP_ADD_A:
                begin
                    if (a_size_reg < CAP)
                        a_size_next = a_size_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                end
                srel_pkg::OP_TEST_B:
                begin
                    if (b_size_reg < CAP)
                    begin
                        b_size_next = b_size_reg + 1'b1;
                        if (hit)
                            hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                srel_pkg::OP_FINISH:
                begin
                    // drop everything for the next pair of sets
                    a_size_next  = '0;
                    b_size_next  = '0;
                    hit_cnt_next = '0;
                    ovf_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_size_reg  <= '0;
            b_size_reg  <= '0;
            hit_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            a_size_reg  <= a_size_next;
            b_size_reg  <= b_size_next;
            hit_cnt_reg <= hit_cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_comb
    begin
        if (a_size_reg >= b_size_reg)
        begin
            if (hit_cnt_reg == b_size_reg)
                relation = (hit_cnt_reg == a_size_reg) ? srel_pkg::REL_EQUAL
                                                       : srel_pkg::REL_B_SUB_A;
            else if (hit_cnt_reg == '0)
                relation = srel_pkg::REL_DISJOINT;
            else
                relation = srel_pkg::REL_OVERLAP;
        end
        else
        begin
            if (hit_cnt_reg == a_size_reg)
                relation = srel_pkg::REL_A_SUB_B;
            else if (hit_cnt_reg == '0)
                relation = srel_pkg::REL_DISJOINT;
            else
                relation = srel_pkg::REL_OVERLAP;
        end
    end

    assign overflow = ovf_reg;

endmodule

// ----- sv/set_relation_classifier_core.sv -----
// ============================================================================
// set_relation_classifier_core
// Loads set A into a match table, tests set B elements against it and reports
// the relation between the two sets on a finish item.
// ============================================================================
// Throughput: one item per cycle while no finish item is held for a waiting
//   result; each item is applied in one pass from the input register, the
//   parallel table compare sets the path; a finish item's result is registered.
// Reset: asynchronous, active low; clears counts, flags and both handshakes.
//   The match table is not cleared; entries at or above the stored count are unused.
module set_relation_classifier_core #(
    parameter int MAX_ELEMENTS = srel_pkg::MAX_ELEMENTS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srel_pkg::TDATA_IN_W-1:0]  s_tdata,   // [31:0] element
    input  logic [srel_pkg::OP_W-1:0]        s_tuser,   // [1:0] op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srel_pkg::TDATA_OUT_W-1:0] m_tdata    // [2:0] relation, [3] overflow
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic                              in_valid_reg;
    logic [srel_pkg::OP_W-1:0]         op_reg;
    logic [srel_pkg::ELEM_W-1:0]       elem_reg;
    logic                              out_valid_reg;
    logic [srel_pkg::REL_W-1:0]        rel_reg;
    logic                              ovf_out_reg;

    logic                              out_free;
    logic                              stall;
    logic                              advance;
    logic                              finish_go;
    srel_pkg::step_t                   step;
    logic                              hit;
    logic                              a_wr_en;
    logic [IDX_W-1:0]                  a_wr_idx;
    logic [CNT_W-1:0]                  a_size;
    logic [srel_pkg::REL_W-1:0]        relation;
    logic                              overflow;

    // hold a finish item while the previous result is still waiting
    assign out_free  = !out_valid_reg || m_tready;
    assign stall     = in_valid_reg && (op_reg == srel_pkg::OP_FINISH) && !out_free;
    assign advance   = in_valid_reg && !stall;
    assign finish_go = advance && (op_reg == srel_pkg::OP_FINISH);
    assign s_tready  = !stall;

    assign step.valid = advance;
    assign step.op    = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (finish_go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg   <= s_tuser;
            elem_reg <= s_tdata[srel_pkg::ELEM_W-1:0];
        end
        if (finish_go)
        begin
            rel_reg     <= relation;
            ovf_out_reg <= overflow;
        end
    end

    srel_match_table #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .CNT_W        (CNT_W),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (a_wr_en),
        .wr_idx   (a_wr_idx),
        .wr_data  (elem_reg),
        .cmp_data (elem_reg),
        .a_size   (a_size),
        .hit      (hit)
    );

    srel_tracker #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .CNT_W        (CNT_W),
        .IDX_W        (IDX_W)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .hit      (hit),
        .a_wr_en  (a_wr_en),
        .a_wr_idx (a_wr_idx),
        .a_size   (a_size),
        .relation (relation),
        .overflow (overflow)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(srel_pkg::TDATA_OUT_W - srel_pkg::REL_W - 1){1'b0}},
                       ovf_out_reg, rel_reg};

endmodule

// ----- test/tb_set_relation_classifier_core.sv -----
// ============================================================================
// tb_set_relation_classifier_core
// Self-checking bench for the set relation classifier: directed corner rows,
// capacity overflow bursts, then random set pairs checked against a local
// model of the match table, under several sender/receiver idle mixes.
// ============================================================================
`timescale 1ns / 100ps

module tb_set_relation_classifier_core;

    localparam int CAPACITY     = srel_pkg::MAX_ELEMENTS_DEFAULT;
    localparam int RANDOM_ITEMS = 690;
    localparam int QUIET_LIMIT  = 3000;
    localparam logic [srel_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [srel_pkg::REL_W-1:0] rel;
        logic                       ovf;
    } verdict_t;

    typedef struct packed {
        bit       fixed;
        verdict_t v;
    } pinned_t;

    typedef struct packed {
        logic [srel_pkg::OP_W-1:0]   op;
        logic [srel_pkg::ELEM_W-1:0] elem;
        bit                          fixed;
        logic [srel_pkg::REL_W-1:0]  rel;
        logic                        ovf;
    } plan_row_t;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [srel_pkg::TDATA_IN_W-1:0]  s_tdata  = '0;
    logic [srel_pkg::OP_W-1:0]        s_tuser  = srel_pkg::OP_ADD_A;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [srel_pkg::TDATA_OUT_W-1:0] m_tdata;

    // local copy of the match table and counters
    logic [srel_pkg::ELEM_W-1:0] a_entries [CAPACITY];
    int                          a_count   = 0;
    int                          b_count   = 0;
    int                          hit_count = 0;
    bit                          ovf_seen  = 1'b0;

    verdict_t pending_verdicts[$];
    pinned_t  pinned_verdicts[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int stim_count      = 0;
    int items_accepted  = 0;
    int results_seen    = 0;
    int ovf_results     = 0;
    int errors          = 0;
    int quiet_cycles    = 0;

    set_relation_classifier_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Advance the local model by one item; return 1 when it yields a verdict.
    function automatic bit track_set_item(input logic [srel_pkg::OP_W-1:0] op,
                                          input logic [srel_pkg::ELEM_W-1:0] elem,
                                          output verdict_t v);
        bit hit;
        hit = 1'b0;
        v   = '0;
        case (op)
            srel_pkg::OP_ADD_A:
            begin
                if (a_count < CAPACITY)
                begin
                    a_entries[a_count] = elem;
                    a_count++;
                end
                else
                    ovf_seen = 1'b1;
            end
            srel_pkg::OP_TEST_B:
            begin
                if (b_count < CAPACITY)
                begin
                    for (int i = 0; i < a_count; i++)
                        if (a_entries[i] == elem)
                            hit = 1'b1;
                    if (hit)
                        hit_count++;
                    b_count++;
                end
                else
                    ovf_seen = 1'b1;
            end
            srel_pkg::OP_FINISH:
            begin
                if (a_count >= b_count)
                begin
                    if (hit_count == b_count)
                        v.rel = (hit_count == a_count) ? srel_pkg::REL_EQUAL
                                                       : srel_pkg::REL_B_SUB_A;
                    else if (hit_count == 0)
                        v.rel = srel_pkg::REL_DISJOINT;
                    else
                        v.rel = srel_pkg::REL_OVERLAP;
                end
                else if (hit_count == a_count)
                    v.rel = srel_pkg::REL_A_SUB_B;
                else if (hit_count == 0)
                    v.rel = srel_pkg::REL_DISJOINT;
                else
                    v.rel = srel_pkg::REL_OVERLAP;
                v.ovf     = ovf_seen;
                a_count   = 0;
                b_count   = 0;
                hit_count = 0;
                ovf_seen  = 1'b0;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Both handshakes are sampled in one process, so prediction and checking
    // never race each other.
    always @(posedge clk)
    begin : observe
        verdict_t pred;
        verdict_t want;
        pinned_t  pin;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                items_accepted++;
                if (track_set_item(s_tuser, s_tdata, pred))
                begin
                    pin = pinned_verdicts.pop_front();
                    pending_verdicts = {pending_verdicts, (pin.fixed ? pin.v : pred)};
                end
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tdata[3])
                    ovf_results++;
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected result: relation %0d overflow %0d",
                           m_tdata[2:0], m_tdata[3]);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[2:0] !== want.rel)
                    begin
                        $error("relation: expected %0d, got %0d", want.rel, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[3] !== want.ovf)
                    begin
                        $error("overflow: expected %0d, got %0d", want.ovf, m_tdata[3]);
                        errors++;
                    end
                    if (m_tdata[srel_pkg::TDATA_OUT_W-1:4] !== '0)
                    begin
                        $error("pad: expected 0, got %0h",
                               m_tdata[srel_pkg::TDATA_OUT_W-1:4]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [srel_pkg::OP_W-1:0] op,
                             input logic [srel_pkg::ELEM_W-1:0] elem,
                             input bit fixed, input verdict_t v);
        if (op == srel_pkg::OP_FINISH)
            pinned_verdicts = {pinned_verdicts, pinned_t'{fixed, v}};
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= elem;
        do
            @(posedge clk);
        while (!s_tready);
        if (op != OP_UNUSED)
            stim_count++;
    endtask

    // Hold the sender until every outstanding verdict has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_set();
        logic [srel_pkg::ELEM_W-1:0] a_vals[$];
        logic [srel_pkg::ELEM_W-1:0] b_vals[$];
        logic [srel_pkg::ELEM_W-1:0] tmp;
        logic [31:0]                 draw;
        int                          na;
        int                          nb;
        int                          mode;
        int                          j;
        mode = $urandom_range(5);
        if (mode == 5)
        begin
            // noise: any op in any order, values often from a small pool to get hits
            repeat ($urandom_range(1, 12))
            begin
                draw = $urandom_range(3);
                send_item(draw[srel_pkg::OP_W-1:0],
                          $urandom_range(1) ? $urandom_range(7) : $urandom(), 1'b0, '0);
            end
            send_item(srel_pkg::OP_FINISH, $urandom(), 1'b0, '0);
            return;
        end
        na = ($urandom_range(11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
        repeat (na)
            a_vals = {a_vals, $urandom()};
        case (mode) inside
            0, 1: b_vals = a_vals;
            2:
            begin
                b_vals = a_vals;
                repeat ($urandom_range(1, 4))
                    b_vals = {b_vals, $urandom()};
            end
            3:
            begin
                nb = ($urandom_range(11) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 10);
                repeat (nb)
                    b_vals = {b_vals, $urandom()};
            end
            default:
            begin
                repeat ($urandom_range(1, 10))
                    if (na > 0 && $urandom_range(1))
                        b_vals = {b_vals, a_vals[$urandom_range(na - 1)]};
                    else
                        b_vals = {b_vals, $urandom()};
            end
        endcase
        for (int i = b_vals.size() - 1; i > 0; i--)
        begin
            j         = $urandom_range(i);
            tmp       = b_vals[i];
            b_vals[i] = b_vals[j];
            b_vals[j] = tmp;
        end
        if (mode == 1)
        begin
            nb = $urandom_range(0, na);
            while (b_vals.size() > nb)
                void'(b_vals.pop_back());
        end
        foreach (a_vals[i])
            send_item(srel_pkg::OP_ADD_A, a_vals[i], 1'b0, '0);
        foreach (b_vals[i])
        begin
            if ($urandom_range(19) == 0)
                send_item(OP_UNUSED, $urandom(), 1'b0, '0);
            send_item(srel_pkg::OP_TEST_B, b_vals[i], 1'b0, '0);
        end
        send_item(srel_pkg::OP_FINISH, $urandom(), 1'b0, '0);
    endtask

    plan_row_t plan [25] = '{
        '{srel_pkg::OP_FINISH, 32'h0000_0000, 1'b1, srel_pkg::REL_EQUAL,   1'b0}, // both empty
        '{srel_pkg::OP_ADD_A,  32'h8000_0000, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'h7FFF_FFFF, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_FINISH, 32'hFFFF_FFFF, 1'b1, srel_pkg::REL_B_SUB_A, 1'b0}, // empty B
        '{srel_pkg::OP_TEST_B, 32'hFFFF_FFFF, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_FINISH, 32'h0000_0000, 1'b1, srel_pkg::REL_A_SUB_B, 1'b0}, // empty A
        '{srel_pkg::OP_ADD_A,  32'h0000_0005, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'hFFFF_FFFF, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'hFFFF_FFFF, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'h0000_0005, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_FINISH, 32'h0000_0000, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'h0000_0001, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'h0000_0002, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'h0000_0003, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_FINISH, 32'h0000_0000, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'h0000_0001, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'h0000_0002, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'h0000_0002, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'h0000_0007, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{OP_UNUSED,           32'h0000_0001, 1'b0, srel_pkg::REL_EQUAL,   1'b0}, // no effect
        '{srel_pkg::OP_FINISH, 32'h0000_0000, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_ADD_A,  32'h0000_0009, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'h0000_0009, 1'b0, srel_pkg::REL_EQUAL,   1'b0},
        '{srel_pkg::OP_TEST_B, 32'h0000_0009, 1'b0, srel_pkg::REL_EQUAL,   1'b0}, // duplicate
        '{srel_pkg::OP_FINISH, 32'h0000_0000, 1'b0, srel_pkg::REL_EQUAL,   1'b0}
    };

    int idle_mix  [4] = '{0, 78, 0, 17};
    int stall_mix [4] = '{0, 0, 78, 17};

    initial
    begin : stimulus
        int phase;
        int cur_phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].op, plan[i].elem, plan[i].fixed, {plan[i].rel, plan[i].ovf});

        // capacity bursts: A past the table, then B past the capacity
        repeat (CAPACITY + 1)
            send_item(srel_pkg::OP_ADD_A, $urandom(), 1'b0, '0);
        send_item(srel_pkg::OP_FINISH, 32'h0, 1'b0, '0);
        repeat (CAPACITY + 1)
            send_item(srel_pkg::OP_TEST_B, $urandom(), 1'b0, '0);
        send_item(srel_pkg::OP_FINISH, 32'h0, 1'b0, '0);

        stim_count = 0;
        cur_phase  = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            phase = (stim_count * 4) / RANDOM_ITEMS;
            if (phase != cur_phase)
            begin
                drain();
                cur_phase       = phase;
                sender_idle_pct = idle_mix[phase];
                recv_stall_pct  = stall_mix[phase];
            end
            run_random_set();
        end

        drain();
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);

        $display("Ran %0d items through four idle/stall mixes;", items_accepted);
        $display("%0d verdicts checked, %0d flagged overflow.", results_seen, ovf_results);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/srel_pkg.sv
sv/srel_match_table.sv
sv/srel_tracker.sv
sv/set_relation_classifier_core.sv
test/tb_set_relation_classifier_core.sv
